// ----- design/snbaw_pkg.sv -----
// Shared types, codes and widths of the strided N-D batch address walker.
`default_nettype none
package snbaw_pkg;

	localparam int MAX_DIMS_DEF = 8;

	localparam int ADDR_W   = 48;
	localparam int DIM_W    = 32;
	localparam int LIN_W    = 40;
	localparam int DIV_BITS = 40;
	localparam int BIT_W    = $clog2(DIV_BITS);
	localparam logic [LIN_W:0] COUNT_CAP = {1'b1, {LIN_W{1'b0}}};

	localparam int IN_TDATA_W  = 184;
	localparam int OUT_TDATA_W = 160;

	// request kinds carried on the input tuser
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_NEXT  = 2'd2;

	// configuration register indexes
	localparam int CFG_AW = 2;
	localparam logic [CFG_AW-1:0] REG_NUM_DIMS = 2'd0;
	localparam logic [CFG_AW-1:0] REG_BASE_OUT = 2'd1;
	localparam logic [CFG_AW-1:0] REG_BASE_IN  = 2'd2;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_CAPTURE,
		OP_LOAD,
		OP_CNT_INIT,
		OP_CNT_MUL,
		OP_CNT_ADD,
		OP_START_SET,
		OP_DIV_INIT_DIM,
		OP_DIV_INIT_ROWS,
		OP_DIV_STEP,
		OP_DIV_STORE,
		OP_NX_EMPTY,
		OP_NX_INNER,
		OP_NX_ZERO,
		OP_OUTER_ONE,
		OP_NX_ROWS,
		OP_MAC_INIT,
		OP_MAC_MUL,
		OP_MAC_ACC,
		OP_ADV_MUL,
		OP_ADV_LIN,
		OP_ADV_CARRY,
		OP_NX_PACK,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       idx_end;
		logic       size_zero;
		logic       start_err;
		logic       empty_now;
		logic       inner_zero;
		logic       inner_full;
		logic       outer_one;
		logic       carry_nz;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- design/snbaw_ctrl.sv -----
// Sequencer of the address walker: steps the datapath through each request.
`default_nettype none
module snbaw_ctrl import snbaw_pkg::*; #(
	parameter int MAX_DIMS = MAX_DIMS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	input  dp_stat_t                       stat,
	output dp_cmd_t                        cmd,
	output logic [$clog2(MAX_DIMS+1)-1:0]  idx
);
	localparam int UW = $clog2(MAX_DIMS+1);

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_CNT_MUL, S_CNT_ADD, S_START_SET, S_DIV_PICK, S_DIV_STEP,
		S_DIV_DONE, S_NX_CHECK, S_NX_INNER, S_NX_ROWS, S_MAC_INIT, S_MAC_MUL,
		S_MAC_ACC, S_ADV_MUL, S_ADV_LIN, S_ADV_CARRY, S_NX_PACK, S_OUT
	} state_t;

	state_t            state_q;
	logic [UW-1:0]     idx_q;
	logic [BIT_W-1:0]  bit_q;
	logic              rows_q;
	logic              mvalid_q;
	logic              out_free;
	logic              out_load;

	assign idx      = idx_q;
	assign m_tvalid = mvalid_q;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !mvalid_q || m_tready;
	assign out_load = (state_q == S_OUT) && out_free;

	always_comb begin
		cmd.op = OP_IDLE;
		case (state_q)
			S_IDLE:      if (s_tvalid) cmd.op = OP_CAPTURE;
			S_DECODE: begin
				case (stat.action)
					ACT_LOAD:  cmd.op = OP_LOAD;
					ACT_START: cmd.op = OP_CNT_INIT;
					default:   cmd.op = OP_IDLE;
				endcase
			end
			S_CNT_MUL:   if (!stat.idx_end) cmd.op = OP_CNT_MUL;
			S_CNT_ADD:   cmd.op = OP_CNT_ADD;
			S_START_SET: cmd.op = OP_START_SET;
			S_DIV_PICK:  if (!stat.idx_end && !stat.size_zero) cmd.op = OP_DIV_INIT_DIM;
			S_DIV_STEP:  cmd.op = OP_DIV_STEP;
			S_DIV_DONE:  cmd.op = OP_DIV_STORE;
			S_NX_CHECK:  cmd.op = stat.empty_now ? OP_NX_EMPTY : OP_NX_INNER;
			S_NX_INNER: begin
				if (stat.inner_zero) cmd.op = OP_NX_ZERO;
				else if (stat.inner_full) cmd.op = OP_DIV_INIT_ROWS;
				else cmd.op = OP_OUTER_ONE;
			end
			S_NX_ROWS:   cmd.op = OP_NX_ROWS;
			S_MAC_INIT:  cmd.op = OP_MAC_INIT;
			S_MAC_MUL:   if (!stat.idx_end) cmd.op = OP_MAC_MUL;
			S_MAC_ACC:   cmd.op = OP_MAC_ACC;
			S_ADV_MUL:   cmd.op = OP_ADV_MUL;
			S_ADV_LIN:   cmd.op = OP_ADV_LIN;
			S_ADV_CARRY: if (!stat.idx_end && stat.carry_nz) cmd.op = OP_ADV_CARRY;
			S_NX_PACK:   cmd.op = OP_NX_PACK;
			S_OUT:       if (out_free) cmd.op = OP_OUT_LOAD;
			default:     cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			bit_q    <= '0;
			rows_q   <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			if (out_load) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_DECODE;
				S_DECODE: begin
					idx_q <= '0;
					case (stat.action)
						ACT_START: state_q <= S_CNT_MUL;
						ACT_NEXT:  state_q <= S_NX_CHECK;
						default:   state_q <= S_IDLE;
					endcase
				end
				S_CNT_MUL: state_q <= stat.idx_end ? S_START_SET : S_CNT_ADD;
				S_CNT_ADD: begin
					idx_q   <= idx_q + UW'(1);
					state_q <= S_CNT_MUL;
				end
				S_START_SET: begin
					idx_q   <= '0;
					state_q <= stat.start_err ? S_IDLE : S_DIV_PICK;
				end
				S_DIV_PICK: begin
					if (stat.idx_end) begin
						state_q <= S_IDLE;
					end else if (stat.size_zero) begin
						idx_q <= idx_q + UW'(1);
					end else begin
						bit_q   <= '0;
						rows_q  <= 1'b0;
						state_q <= S_DIV_STEP;
					end
				end
				S_DIV_STEP: begin
					bit_q <= bit_q + BIT_W'(1);
					if (bit_q == BIT_W'(DIV_BITS-1)) state_q <= rows_q ? S_NX_ROWS : S_DIV_DONE;
				end
				S_DIV_DONE: begin
					idx_q   <= idx_q + UW'(1);
					state_q <= S_DIV_PICK;
				end
				S_NX_CHECK: state_q <= stat.empty_now ? S_OUT : S_NX_INNER;
				S_NX_INNER: begin
					if (stat.inner_zero) begin
						state_q <= S_OUT;
					end else if (stat.inner_full) begin
						bit_q   <= '0;
						rows_q  <= 1'b1;
						state_q <= S_DIV_STEP;
					end else begin
						state_q <= S_MAC_INIT;
					end
				end
				S_NX_ROWS: state_q <= S_MAC_INIT;
				S_MAC_INIT: begin
					idx_q   <= '0;
					state_q <= S_MAC_MUL;
				end
				S_MAC_MUL: state_q <= stat.idx_end ? S_ADV_MUL : S_MAC_ACC;
				S_MAC_ACC: begin
					idx_q   <= idx_q + UW'(1);
					state_q <= S_MAC_MUL;
				end
				S_ADV_MUL: state_q <= S_ADV_LIN;
				S_ADV_LIN: begin
					idx_q   <= stat.outer_one ? UW'(0) : UW'(1);
					state_q <= S_ADV_CARRY;
				end
				S_ADV_CARRY: begin
					if (stat.idx_end || !stat.carry_nz) state_q <= S_NX_PACK;
					else idx_q <= idx_q + UW'(1);
				end
				S_NX_PACK: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/snbaw_dp.sv -----
// Datapath of the address walker: dimension tables, walk position,
// multipliers, a shared divider and the result register.
`default_nettype none
module snbaw_dp import snbaw_pkg::*; #(
	parameter int MAX_DIMS = MAX_DIMS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [CFG_AW-1:0]              cfg_addr,
	input  wire  [ADDR_W-1:0]              cfg_wdata,
	input  wire  [1:0]                     in_action,
	input  wire  [2:0]                     in_dim_index,
	input  wire  [DIM_W-1:0]               in_dim_size,
	input  wire  [DIM_W-1:0]               in_stride_out,
	input  wire  [DIM_W-1:0]               in_stride_in,
	input  wire  [LIN_W-1:0]               in_range_begin,
	input  wire  [LIN_W-1:0]               in_range_end,
	input  dp_cmd_t                        cmd,
	input  wire  [$clog2(MAX_DIMS+1)-1:0]  idx,
	output dp_stat_t                       stat,
	output logic [ADDR_W-1:0]              addr_out,
	output logic [ADDR_W-1:0]              addr_in,
	output logic [DIM_W-1:0]               inner_count,
	output logic [DIM_W-1:0]               outer_count,
	output logic                           last_batch,
	output logic                           empty_res,
	output logic                           range_error
);
	localparam int UW = $clog2(MAX_DIMS+1);
	localparam int DW = $clog2(MAX_DIMS);

	logic [DIM_W-1:0]  size_q [MAX_DIMS];
	logic [DIM_W-1:0]  so_q   [MAX_DIMS];
	logic [DIM_W-1:0]  si_q   [MAX_DIMS];
	logic [DIM_W-1:0]  pos_q  [MAX_DIMS];
	logic [3:0]        num_dims_q;
	logic [ADDR_W-1:0] base_out_q, base_in_q;
	logic [LIN_W-1:0]  lin_q, end_q;
	logic              err_q;

	logic [1:0]        act_q;
	logic [2:0]        dimi_q;
	logic [DIM_W-1:0]  dsize_q, dso_q, dsi_q;
	logic [LIN_W-1:0]  beg_q, endin_q;

	logic [LIN_W:0]    cnt_q;
	logic [63:0]       prod_q;
	logic [LIN_W:0]    phi_q;
	logic [LIN_W-1:0]  dvd_q, rem_q;
	logic [DIM_W-1:0]  rmd_q, dsr_q;
	logic [DIM_W-1:0]  inner_q, outer_q, carry_q;
	logic [63:0]       mo_q, mi_q;
	logic [ADDR_W-1:0] acc_o_q, acc_i_q;

	logic [ADDR_W-1:0] res_ao_q, res_ai_q;
	logic [DIM_W-1:0]  res_inner_q, res_outer_q;
	logic              res_last_q, res_empty_q, res_err_q;

	logic [DW-1:0]     ix;
	logic [UW-1:0]     used;
	logic              used_gt1;
	logic [DIM_W-1:0]  size0, pos0, size1v, pos1v, avail0, avail1;
	logic [LIN_W-1:0]  rem_c;
	logic [DIM_W-1:0]  inner_c, outer_c;
	logic [72:0]       sum_c;
	logic              st_err_c;
	logic [LIN_W-1:0]  st_end_c;
	logic [DIM_W:0]    dv_r, dv_diff;
	logic              dv_ge;
	logic [DIM_W:0]    ap, ap_new;
	logic              ap_ge;

	assign ix = idx[DW-1:0];

	always_comb begin
		if (num_dims_q == 4'd0) used = UW'(1);
		else if (int'(num_dims_q) > MAX_DIMS) used = UW'(MAX_DIMS);
		else used = UW'(num_dims_q);
	end

	assign used_gt1 = used > UW'(1);
	assign size0    = size_q[0];
	assign pos0     = pos_q[0];
	assign size1v   = used_gt1 ? size_q[1] : DIM_W'(1);
	assign pos1v    = used_gt1 ? pos_q[1] : '0;
	assign avail0   = (size0 > pos0) ? size0 - pos0 : '0;
	assign avail1   = (size1v > pos1v) ? size1v - pos1v : '0;
	assign rem_c    = end_q - lin_q;
	assign inner_c  = (LIN_W'(avail0) < rem_c) ? avail0 : rem_c[DIM_W-1:0];

	// rows that fit: the quotient sits in the dividend register
	always_comb begin
		outer_c = (LIN_W'(avail1) < dvd_q) ? avail1 : dvd_q[DIM_W-1:0];
		if (outer_c == '0) outer_c = DIM_W'(1);
	end

	assign sum_c    = 73'(prod_q) + {phi_q, 32'b0};
	assign st_err_c = ((LIN_W+1)'(beg_q) > cnt_q) ||
	                  (((LIN_W+1)'(beg_q) == cnt_q) && (endin_q > beg_q));
	assign st_end_c = ((LIN_W+1)'(endin_q) < cnt_q) ? endin_q : cnt_q[LIN_W-1:0];

	assign dv_r    = {rmd_q, dvd_q[LIN_W-1]};
	assign dv_diff = dv_r - {1'b0, dsr_q};
	assign dv_ge   = dv_r >= {1'b0, dsr_q};

	assign ap     = {1'b0, pos_q[ix]} + {1'b0, carry_q};
	assign ap_ge  = ap >= {1'b0, size_q[ix]};
	assign ap_new = ap_ge ? ap - {1'b0, size_q[ix]} : ap;

	always_comb begin
		stat.action     = act_q;
		stat.idx_end    = (idx == used);
		stat.size_zero  = (size_q[ix] == '0);
		stat.start_err  = st_err_c;
		stat.empty_now  = err_q || (lin_q >= end_q);
		stat.inner_zero = (inner_q == '0);
		stat.inner_full = (inner_q == size0);
		stat.outer_one  = (outer_q == DIM_W'(1));
		stat.carry_nz   = (carry_q != '0);
	end

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIMS; i++) begin
				size_q[i] <= DIM_W'(1);
				so_q[i]   <= '0;
				si_q[i]   <= '0;
				pos_q[i]  <= '0;
			end
			num_dims_q <= 4'd1;
			base_out_q <= '0;
			base_in_q  <= '0;
			lin_q      <= '0;
			end_q      <= '0;
			err_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_NUM_DIMS: num_dims_q <= cfg_wdata[3:0];
					REG_BASE_OUT: base_out_q <= cfg_wdata;
					REG_BASE_IN:  base_in_q  <= cfg_wdata;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_LOAD: begin
					if (int'(dimi_q) < MAX_DIMS) begin
						size_q[DW'(dimi_q)] <= dsize_q;
						so_q[DW'(dimi_q)]   <= dso_q;
						si_q[DW'(dimi_q)]   <= dsi_q;
					end
				end
				OP_START_SET: begin
					for (int i = 0; i < MAX_DIMS; i++) pos_q[i] <= '0;
					end_q <= st_end_c;
					err_q <= st_err_c;
					lin_q <= st_err_c ? st_end_c : beg_q;
				end
				OP_DIV_STORE: pos_q[ix] <= rmd_q;
				OP_NX_ZERO:   lin_q <= end_q;
				OP_ADV_LIN:   lin_q <= lin_q + prod_q[LIN_W-1:0];
				OP_ADV_CARRY: pos_q[ix] <= ap_new[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				act_q   <= in_action;
				dimi_q  <= in_dim_index;
				dsize_q <= in_dim_size;
				dso_q   <= in_stride_out;
				dsi_q   <= in_stride_in;
				beg_q   <= in_range_begin;
				endin_q <= in_range_end;
			end
			OP_CNT_INIT: cnt_q <= (LIN_W+1)'(1);
			OP_CNT_MUL: begin
				prod_q <= 64'(cnt_q[DIM_W-1:0]) * 64'(size_q[ix]);
				phi_q  <= (LIN_W+1)'(cnt_q[LIN_W:DIM_W]) * (LIN_W+1)'(size_q[ix]);
			end
			OP_CNT_ADD: cnt_q <= (sum_c > 73'(COUNT_CAP)) ? COUNT_CAP : sum_c[LIN_W:0];
			OP_START_SET: dvd_q <= beg_q;
			OP_DIV_INIT_DIM: begin
				dsr_q <= size_q[ix];
				rmd_q <= '0;
			end
			OP_DIV_INIT_ROWS: begin
				dvd_q <= rem_q;
				dsr_q <= size0;
				rmd_q <= '0;
			end
			OP_DIV_STEP: begin
				rmd_q <= dv_ge ? dv_diff[DIM_W-1:0] : dv_r[DIM_W-1:0];
				dvd_q <= {dvd_q[LIN_W-2:0], dv_ge};
			end
			OP_NX_EMPTY, OP_NX_ZERO: begin
				res_ao_q    <= '0;
				res_ai_q    <= '0;
				res_inner_q <= '0;
				res_outer_q <= '0;
				res_last_q  <= 1'b0;
				res_empty_q <= 1'b1;
				res_err_q   <= err_q;
			end
			OP_NX_INNER: begin
				rem_q   <= rem_c;
				inner_q <= inner_c;
			end
			OP_OUTER_ONE: outer_q <= DIM_W'(1);
			OP_NX_ROWS:   outer_q <= outer_c;
			OP_MAC_INIT: begin
				acc_o_q <= base_out_q;
				acc_i_q <= base_in_q;
			end
			OP_MAC_MUL: begin
				mo_q <= 64'(pos_q[ix]) * 64'(so_q[ix]);
				mi_q <= 64'(pos_q[ix]) * 64'(si_q[ix]);
			end
			OP_MAC_ACC: begin
				acc_o_q <= acc_o_q + mo_q[ADDR_W-1:0];
				acc_i_q <= acc_i_q + mi_q[ADDR_W-1:0];
			end
			OP_ADV_MUL: prod_q <= 64'(inner_q) * 64'(outer_q);
			OP_ADV_LIN: carry_q <= (outer_q == DIM_W'(1)) ? inner_q : outer_q;
			OP_ADV_CARRY: carry_q <= ap_ge ? DIM_W'(1) : '0;
			OP_NX_PACK: begin
				res_ao_q    <= acc_o_q;
				res_ai_q    <= acc_i_q;
				res_inner_q <= inner_q;
				res_outer_q <= outer_q;
				res_last_q  <= lin_q >= end_q;
				res_empty_q <= 1'b0;
				res_err_q   <= err_q;
			end
			OP_OUT_LOAD: begin
				addr_out    <= res_ao_q;
				addr_in     <= res_ai_q;
				inner_count <= res_inner_q;
				outer_count <= res_outer_q;
				last_batch  <= res_last_q;
				empty_res   <= res_empty_q;
				range_error <= res_err_q;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- design/strided_nd_batch_address_walker_top.sv -----
// Top level of the strided N-D batch address walker.
//
// Requests arrive on the s_axis channel, kind on tuser: load one dimension
// entry (size and two byte strides), start a linear element range, or ask
// for the next 2-D batch. Only a next request returns a result on m_axis:
// both batch start addresses, inner and outer counts, tlast set on the batch
// that ends the range, tuser flags for an empty answer and a bad range begin.
// num_dims and the two base addresses go on the cfg port; the user must write
// them only while the block is idle, which the block itself does not enforce.
// One request is worked on at a time; s_axis_tready is high only when idle.
// Load writes one table entry. Start forms the element count of the D
// dimensions in use, then splits range_begin into per-dimension positions
// with the restoring divider (one quotient bit a cycle), for each dimension
// of nonzero size. Next: the multipliers walk the dimensions for both
// addresses, then the carry chain advances the position; a full-row batch
// first runs the divider for the row count. Empty answers skip the walk.
// The result sits in an output register; the next request is accepted while
// it waits, and a following result holds until the receiver takes it.
// Reset: tables hold size 1 and stride 0, the range is empty, num_dims is 1.
`default_nettype none
module strided_nd_batch_address_walker_top import snbaw_pkg::*; #(
	parameter int MAX_DIMS = MAX_DIMS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire [CFG_AW-1:0]       cfg_addr,
	input  wire [ADDR_W-1:0]       cfg_wdata,
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	// dim_index, dim_size, stride_out, stride_in, range_begin, range_end, pad
	input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
	// action
	input  wire [1:0]              s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	// addr_out, addr_in, inner_count, outer_count
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// empty_res, range_error
	output logic [1:0]             m_axis_tuser,
	output logic                   m_axis_tlast
);
	localparam int UW = $clog2(MAX_DIMS+1);

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [UW-1:0]     idx;
	logic [ADDR_W-1:0] addr_out, addr_in;
	logic [DIM_W-1:0]  inner_count, outer_count;
	logic              last_batch, empty_res, range_error;

	snbaw_ctrl #(.MAX_DIMS(MAX_DIMS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.stat     (stat),
		.cmd      (cmd),
		.idx      (idx)
	);

	// unpack the request fields, lowest field first
	snbaw_dp #(.MAX_DIMS(MAX_DIMS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.in_action      (s_axis_tuser),
		.in_dim_index   (s_axis_tdata[2:0]),
		.in_dim_size    (s_axis_tdata[34:3]),
		.in_stride_out  (s_axis_tdata[66:35]),
		.in_stride_in   (s_axis_tdata[98:67]),
		.in_range_begin (s_axis_tdata[138:99]),
		.in_range_end   (s_axis_tdata[178:139]),
		.cmd            (cmd),
		.idx            (idx),
		.stat           (stat),
		.addr_out       (addr_out),
		.addr_in        (addr_in),
		.inner_count    (inner_count),
		.outer_count    (outer_count),
		.last_batch     (last_batch),
		.empty_res      (empty_res),
		.range_error    (range_error)
	);

	assign m_axis_tdata = {outer_count, inner_count, addr_in, addr_out};
	assign m_axis_tuser = {range_error, empty_res};
	assign m_axis_tlast = last_batch;

endmodule
`default_nettype wire
